@@ src/tlsrc_pkg.sv @@
// shared types, constants and helpers for the text line splitter
`default_nettype none

package tlsrc_pkg;

    // widths fixed by the byte offset and register fields
    localparam int POS_BITS = 48;
    localparam int REG_BITS = 48;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;
    localparam logic [REG_BITS-1:0] REG_MAX = '1;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // results per input word
    localparam int RES_MAX = 4;
    localparam int RES_CW  = $clog2(RES_MAX + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_BOM   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_BLANK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROWS    = 3'd4;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] BOM_0    = 8'hef;
    localparam logic [7:0] BOM_1    = 8'hbb;
    localparam logic [7:0] BOM_2    = 8'hbf;

    // output stream packing
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_USED_W  = 8 + 1 + REG_BITS + 1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_BYTE = 2'd1,
        KIND_EOL  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [REG_BITS-1:0] split_start;
        logic [REG_BITS-1:0] split_end;
        logic [REG_BITS-1:0] max_rows;
        logic                strip_bom;
        logic                skip_blank;
    } t_cfg;

    // offset classes against the split window
    typedef struct packed {
        logic lt_start;
        logic at_start_m1;
        logic ge_end;
        logic blocked;
    } t_pos;

    // classified input word handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eof;
        t_pos       pos;
        logic       bom_cond;
        logic [1:0] p_lo;
        logic       byte_ok;
    } t_cls;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          out_byte;
        logic                line_blank;
        logic [REG_BITS-1:0] row_count;
    } t_res;

    // classify one byte offset against split start and end
    function automatic t_pos classify_pos(input logic [POS_BITS-1:0] p, input t_cfg cfg);
        t_pos r;
        logic unlimited;
        unlimited     = (cfg.split_end == REG_MAX);
        r.lt_start    = (p < cfg.split_start);
        r.at_start_m1 = (p == REG_BITS'(cfg.split_start - 1'b1));
        r.ge_end      = !unlimited && (p >= cfg.split_end);
        r.blocked     = !unlimited && ((cfg.split_end == '0) ||
                                       (p >= REG_BITS'(cfg.split_end - 1'b1)));
        return r;
    endfunction

    // expected byte of the utf-8 byte order mark
    function automatic logic [7:0] mark_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = BOM_0;
            2'd1:    m = BOM_1;
            default: m = BOM_2;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ src/tlsrc_front.sv @@
// front end: byte offset counter and per-byte classification
`default_nettype none

module tlsrc_front
    import tlsrc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cls            o_cls
);

    logic [POS_BITS-1:0] r_pos;
    logic                p_small;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready;

    // offsets 0 to 2 are the only mark candidates
    assign p_small = (r_pos[POS_BITS-1:2] == '0) && (r_pos[1:0] != 2'd3);

    // classification word
    always_comb begin
        o_cls.data_byte = i_data;
        o_cls.eof       = i_last;
        o_cls.pos       = classify_pos(r_pos, i_cfg);
        o_cls.bom_cond  = i_cfg.strip_bom && (i_cfg.split_start == '0) && p_small;
        o_cls.p_lo      = r_pos[1:0];
        o_cls.byte_ok   = (i_data == mark_byte(r_pos[1:0]));
    end

    // saturating byte offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (o_push && (r_pos != POS_MAX)) begin
            r_pos <= POS_BITS'(r_pos + 1'b1);
        end
    end

endmodule

`default_nettype wire

@@ src/tlsrc_fifo.sv @@
// short queue of classified words between front and back
`default_nettype none

module tlsrc_fifo
    import tlsrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_cls,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cls      o_cls
);

    t_cls              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp;
    logic [Q_AW-1:0]   r_rp;
    logic [Q_AW:0]     r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cls;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= Q_AW'(r_wp + 1'b1);
            end
            if (i_pop) begin
                r_rp <= Q_AW'(r_rp + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= (Q_AW+1)'(r_cnt + 1'b1);
            end else if (!i_push && i_pop) begin
                r_cnt <= (Q_AW+1)'(r_cnt - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

@@ src/tlsrc_back.sv @@
// back end: line state, row counter and result serializer
`default_nettype none

module tlsrc_back
    import tlsrc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_q_valid,
    input  wire t_cls i_cls,
    output logic      o_q_pop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res,
    output logic      o_finished,
    output logic      o_last
);

    typedef struct packed {
        logic                cr_pending;
        logic                record_open;
        logic                discarding;
        logic                seen_nonblank;
        logic                stopped;
        logic [REG_BITS-1:0] rows;
    } t_state;

    typedef struct packed {
        t_state st;
        logic   emit;
        t_res   res;
    } t_feed;

    // close the open line, counting it under the blank rule
    function automatic t_feed close_line(input t_state s_in, input logic skip_blank);
        t_feed f;
        f.st = s_in;
        if ((!skip_blank || s_in.seen_nonblank) && (s_in.rows != REG_MAX)) begin
            f.st.rows = REG_BITS'(s_in.rows + 1'b1);
        end
        f.emit           = 1'b1;
        f.res.kind       = KIND_EOL;
        f.res.out_byte   = '0;
        f.res.line_blank = !s_in.seen_nonblank;
        f.res.row_count  = f.st.rows;
        f.st.record_open   = 1'b0;
        f.st.seen_nonblank = 1'b0;
        return f;
    endfunction

    // one byte through the line splitter
    function automatic t_feed feed(input t_state s_in, input logic [7:0] b, input t_pos pc,
                                   input logic skip_blank, input logic lim_same,
                                   input logic lim_inc);
        t_feed f;
        logic  sep;
        logic  done;
        logic  inc;
        f.st   = s_in;
        f.emit = 1'b0;
        f.res  = '0;
        sep    = (b == CH_LF) || (b == CH_CR);
        done   = s_in.stopped;
        inc    = 1'b0;
        // lf right after cr is swallowed
        if (!done && f.st.cr_pending) begin
            f.st.cr_pending = 1'b0;
            if (b == CH_LF) begin
                done = 1'b1;
            end
        end
        // ahead of split start
        if (!done && pc.lt_start) begin
            if (pc.at_start_m1) begin
                f.st.discarding = !sep;
                if (sep) begin
                    f.st.cr_pending = (b == CH_CR);
                    if (pc.blocked) begin
                        f.st.stopped = 1'b1;
                    end
                end
            end
            done = 1'b1;
        end
        // skipping the partial line at split start
        if (!done && f.st.discarding) begin
            if (sep) begin
                f.st.discarding = 1'b0;
                f.st.cr_pending = (b == CH_CR);
                if (pc.blocked) begin
                    f.st.stopped = 1'b1;
                end
            end
            done = 1'b1;
        end
        // a new line may only open below split end
        if (!done && !f.st.record_open) begin
            if (pc.ge_end) begin
                f.st.stopped = 1'b1;
                done = 1'b1;
            end else begin
                f.st.record_open   = 1'b1;
                f.st.seen_nonblank = 1'b0;
            end
        end
        if (!done) begin
            if (sep) begin
                inc = (!skip_blank || f.st.seen_nonblank) && (f.st.rows != REG_MAX);
                f = close_line(f.st, skip_blank);
                f.st.cr_pending = (b == CH_CR);
                if ((inc ? lim_inc : lim_same) || pc.blocked) begin
                    f.st.stopped = 1'b1;
                end
            end else begin
                if (b > CH_SPACE) begin
                    f.st.seen_nonblank = 1'b1;
                end
                f.emit           = 1'b1;
                f.res.kind       = KIND_BYTE;
                f.res.out_byte   = b;
                f.res.line_blank = 1'b0;
                f.res.row_count  = f.st.rows;
            end
        end
        return f;
    endfunction

    t_state            r_state;
    logic [1:0]        r_held;
    t_res              r_res [RES_MAX];
    logic [RES_CW-1:0] r_left;
    logic              r_fin;

    t_state            n_state;
    logic [1:0]        n_held;
    t_res              n_res [RES_MAX];
    logic [RES_CW-1:0] n_cnt;

    t_feed             fr;
    t_pos              pos0;
    t_pos              pos1;
    logic              ge_max;
    logic              ge_max_m1;
    logic              bom_path;
    logic              match;
    logic [1:0]        rel;
    logic              load;
    logic              take;

    assign take     = o_valid && i_ready;
    assign load     = i_q_valid && ((r_left == '0) || ((r_left == RES_CW'(1)) && i_ready));
    assign o_q_pop  = load;
    assign o_valid  = (r_left != '0);
    assign o_last   = (r_left == RES_CW'(1));
    assign o_res    = r_res[0];
    assign o_finished = r_fin;

    // row limit against the current and the incremented count
    assign ge_max    = (r_state.rows >= i_cfg.max_rows);
    assign ge_max_m1 = (i_cfg.max_rows == '0) ||
                       (r_state.rows >= REG_BITS'(i_cfg.max_rows - 1'b1));
    assign pos0      = classify_pos('0, i_cfg);
    assign pos1      = classify_pos(POS_BITS'(1), i_cfg);

    // results of one word
    always_comb begin
        n_state  = r_state;
        n_held   = r_held;
        n_cnt    = '0;
        bom_path = 1'b0;
        match    = 1'b0;
        rel      = '0;
        fr       = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            n_res[i] = '0;
        end
        if (!n_state.stopped && ge_max) begin
            n_state.stopped = 1'b1;
        end
        if (n_state.stopped) begin
            n_held = '0;
        end
        if (!n_state.stopped) begin
            bom_path = i_cls.bom_cond && (n_held == i_cls.p_lo);
            match    = bom_path && i_cls.byte_ok;
            if (match && (i_cls.p_lo == 2'd2)) begin
                n_held = '0;
            end else if (match && !i_cls.eof) begin
                n_held = 2'(n_held + 1'b1);
            end else begin
                // release held mark bytes ahead of this one
                rel    = n_held;
                n_held = '0;
                if (rel != 2'd0) begin
                    fr = feed(n_state, BOM_0, pos0, i_cfg.skip_blank, ge_max, ge_max_m1);
                    n_state = fr.st;
                    if (fr.emit) begin
                        n_res[n_cnt[1:0]] = fr.res;
                        n_cnt = RES_CW'(n_cnt + 1'b1);
                    end
                end
                if (rel == 2'd2) begin
                    fr = feed(n_state, BOM_1, pos1, i_cfg.skip_blank, ge_max, ge_max_m1);
                    n_state = fr.st;
                    if (fr.emit) begin
                        n_res[n_cnt[1:0]] = fr.res;
                        n_cnt = RES_CW'(n_cnt + 1'b1);
                    end
                end
                fr = feed(n_state, i_cls.data_byte, i_cls.pos, i_cfg.skip_blank,
                          ge_max, ge_max_m1);
                n_state = fr.st;
                if (fr.emit) begin
                    n_res[n_cnt[1:0]] = fr.res;
                    n_cnt = RES_CW'(n_cnt + 1'b1);
                end
            end
            // end of file closes an open line
            if (i_cls.eof) begin
                if (!n_state.stopped && n_state.record_open) begin
                    fr = close_line(n_state, i_cfg.skip_blank);
                    n_state = fr.st;
                    n_res[n_cnt[1:0]] = fr.res;
                    n_cnt = RES_CW'(n_cnt + 1'b1);
                end
                n_state.stopped = 1'b1;
                n_held = '0;
            end
        end
        // a word with no result still reports once
        if (n_cnt == '0) begin
            n_res[0].kind       = KIND_NONE;
            n_res[0].out_byte   = '0;
            n_res[0].line_blank = 1'b0;
            n_res[0].row_count  = n_state.rows;
            n_cnt = RES_CW'(1);
        end
    end

    // state and result buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_held  <= '0;
            r_left  <= '0;
            r_fin   <= 1'b0;
        end else if (load) begin
            r_state <= n_state;
            r_held  <= n_held;
            r_left  <= n_cnt;
            r_fin   <= n_state.stopped;
            for (int i = 0; i < RES_MAX; i++) begin
                r_res[i] <= n_res[i];
            end
        end else if (take) begin
            r_left <= RES_CW'(r_left - 1'b1);
            for (int i = 0; i < RES_MAX - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/text_line_splitter_row_counter_unit.sv @@
// top level of the text line splitter with row counter
// an accepted byte word is written into the queue, then loaded into the result buffer
//   once the back end is free; the receiver takes its results from that buffer
// throughput: one byte word per cycle when each byte gives one result and the receiver
//   is ready; a byte with more results (held mark bytes, end of file) stalls the back end
// reset: synchronous active low; clears offset, line state, row count and queue
`default_nettype none

module text_line_splitter_row_counter_unit
    import tlsrc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [REG_BITS-1:0]    i_cfg_data,
    // input bytes
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tlast,   // end_of_file
    // results
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] out_byte, [8] line_blank, [56:9] row_count, [57] finished, rest zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [1:0]                  m_axis_tuser,   // [1:0] kind
    output logic                        m_axis_tlast    // last_of_run
);

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_cls front_cls;
    t_cls q_cls;
    t_res res;
    logic finished;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.split_start <= '0;
            r_cfg.split_end   <= REG_MAX;
            r_cfg.strip_bom   <= 1'b0;
            r_cfg.skip_blank  <= 1'b0;
            r_cfg.max_rows    <= REG_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPLIT_START: r_cfg.split_start <= i_cfg_data;
                CFG_SPLIT_END:   r_cfg.split_end   <= i_cfg_data;
                CFG_STRIP_BOM:   r_cfg.strip_bom   <= i_cfg_data[0];
                CFG_SKIP_BLANK:  r_cfg.skip_blank  <= i_cfg_data[0];
                CFG_MAX_ROWS:    r_cfg.max_rows    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tlsrc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cls    (front_cls)
    );

    tlsrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cls   (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cls   (q_cls)
    );

    tlsrc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (q_valid),
        .i_cls      (q_cls),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (res),
        .o_finished (finished),
        .o_last     (m_axis_tlast)
    );

    // output word packing
    assign m_axis_tdata = {(OUT_TDATA_W - OUT_USED_W)'(0), finished, res.row_count,
                           res.line_blank, res.out_byte};
    assign m_axis_tuser = res.kind;

`ifndef SYNTH
    // results of one byte leave without gaps
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("gap inside a run of results");

    // row count never falls within a run
    a_rows_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast
            |=> res.row_count >= $past(res.row_count))
        else $error("row count dropped within a run");

    // only content words carry a byte
    a_byte_only_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (res.kind != KIND_BYTE) |-> res.out_byte == '0)
        else $error("byte on a non-content word");

    // blank flag only on end of line
    a_blank_only_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.line_blank |-> res.kind == KIND_EOL)
        else $error("blank flag outside end of line");
`endif

endmodule

`default_nettype wire

@@ verif/split_result_checker.sv @@
// result checker for the text line splitter: predicts every result word and compares
`timescale 1ns / 1ps

module split_result_checker
    import tlsrc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration channel
    input  wire logic                   i_cfg_valid,
    input  wire logic                   i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [REG_BITS-1:0]    i_cfg_data,
    // byte channel
    input  wire logic                   i_in_valid,
    input  wire logic                   i_in_ready,
    input  wire logic [7:0]             i_in_data,
    input  wire logic                   i_in_last,
    // result channel
    input  wire logic                   i_out_valid,
    input  wire logic                   i_out_ready,
    input  wire logic [OUT_TDATA_W-1:0] i_out_data,
    input  wire logic [1:0]             i_out_user,
    input  wire logic                   i_out_last,
    output logic [31:0]                 o_errors,
    output logic [31:0]                 o_pending,
    output logic [REG_BITS-1:0]         o_rows
);

    // bit positions of the result word
    localparam int ROWS_LSB = 9;
    localparam int DONE_BIT = ROWS_LSB + REG_BITS;

    // mark bytes, first one in the low byte
    localparam logic [23:0] MARK_SEQ = {BOM_2, BOM_1, BOM_0};

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          data;
        logic                blank;
        logic [REG_BITS-1:0] rows;
        logic                done;
        logic                last;
    } t_line_event;

    t_line_event awaited_results[$];
    t_line_event word_results[$];

    // predicted registers
    logic [REG_BITS-1:0] win_start;
    logic [REG_BITS-1:0] win_end;
    logic [REG_BITS-1:0] row_limit;
    logic                strip_mark;
    logic                skip_empty;

    // predicted scan state
    logic [POS_BITS-1:0] offset;
    logic [REG_BITS-1:0] row_total;
    logic                after_cr;
    logic                in_line;
    logic                skipping_head;
    logic                has_ink;
    logic                halted;
    int unsigned         marks_held;

    int unsigned         err_count = 0;
    int unsigned         result_no = 0;

    assign o_errors = err_count;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("checker: result %0d %s: got %0h, want %0h", result_no, what, got, want);
    endtask

    // a new line may not start after offset p
    function automatic logic start_refused(input logic [POS_BITS-1:0] p);
        if (win_end == REG_MAX)
            return 1'b0;
        return (win_end == '0) || (p >= win_end - 1'b1);
    endfunction

    task automatic add_event(input t_kind k, input logic [7:0] d, input logic bl);
        t_line_event ev;
        if (word_results.size() < RES_MAX) begin
            ev.kind  = k;
            ev.data  = d;
            ev.blank = bl;
            ev.rows  = row_total;
            ev.done  = 1'b0;
            ev.last  = 1'b0;
            word_results.push_back(ev);
        end
    endtask

    task automatic close_line();
        if ((!skip_empty || has_ink) && row_total != REG_MAX)
            row_total = row_total + 1'b1;
        add_event(KIND_EOL, 8'h00, !has_ink);
        in_line = 1'b0;
        has_ink = 1'b0;
    endtask

    // one byte through the line splitter
    task automatic take_byte(input logic [7:0] b, input logic [POS_BITS-1:0] p);
        logic sep;
        sep = (b == CH_LF) || (b == CH_CR);
        if (halted)
            return;
        // lf right after cr belongs to that cr
        if (after_cr) begin
            after_cr = 1'b0;
            if (b == CH_LF)
                return;
        end
        // ahead of the split start: only the byte just before it matters
        if (p < win_start) begin
            if (p == win_start - 1'b1) begin
                skipping_head = !sep;
                if (sep) begin
                    after_cr = (b == CH_CR);
                    if (start_refused(p))
                        halted = 1'b1;
                end
            end
            return;
        end
        // partial line at the split start
        if (skipping_head) begin
            if (sep) begin
                skipping_head = 1'b0;
                after_cr = (b == CH_CR);
                if (start_refused(p))
                    halted = 1'b1;
            end
            return;
        end
        if (!in_line) begin
            if (win_end != REG_MAX && p >= win_end) begin
                halted = 1'b1;
                return;
            end
            in_line = 1'b1;
            has_ink = 1'b0;
        end
        if (sep) begin
            close_line();
            after_cr = (b == CH_CR);
            if (row_total >= row_limit || start_refused(p))
                halted = 1'b1;
        end else begin
            if (b > CH_SPACE)
                has_ink = 1'b1;
            add_event(KIND_BYTE, b, 1'b0);
        end
    endtask

    // expected results of one accepted byte word
    task automatic predict_word(input logic [7:0] b, input logic eof);
        logic [POS_BITS-1:0] p;
        logic                on_mark;
        logic                mark_hit;
        int unsigned         n;
        t_line_event         ev;
        p = offset;
        word_results.delete();
        if (!halted && row_total >= row_limit)
            halted = 1'b1;
        if (halted)
            marks_held = 0;
        if (!halted) begin
            on_mark  = strip_mark && (win_start == '0) && (p < 3) && (marks_held == p);
            mark_hit = on_mark && (b == MARK_SEQ[8*p[1:0] +: 8]);
            if (mark_hit && p == 2) begin
                marks_held = 0;
            end else if (mark_hit && !eof) begin
                marks_held++;
            end else begin
                // held mark bytes go out as plain bytes ahead of this one
                n = (marks_held > 2) ? 2 : marks_held;
                marks_held = 0;
                for (int i = 0; i < n; i++)
                    take_byte(MARK_SEQ[8*i +: 8], POS_BITS'(i));
                take_byte(b, p);
            end
            if (eof) begin
                if (!halted && in_line)
                    close_line();
                halted = 1'b1;
                marks_held = 0;
            end
        end
        if (p != POS_MAX)
            offset = p + 1'b1;
        if (word_results.size() == 0)
            add_event(KIND_NONE, 8'h00, 1'b0);
        foreach (word_results[k]) begin
            ev = word_results[k];
            ev.done = halted;
            ev.last = (k == word_results.size() - 1);
            awaited_results.push_back(ev);
        end
    endtask

    task automatic check_result();
        t_line_event want;
        result_no++;
        if (awaited_results.size() == 0) begin
            report_mismatch("with nothing awaited", i_out_data, 64'h0);
            return;
        end
        want = awaited_results.pop_front();
        if (i_out_user != want.kind)
            report_mismatch("kind", 64'(i_out_user), 64'(want.kind));
        if (i_out_data[7:0] != want.data)
            report_mismatch("out_byte", 64'(i_out_data[7:0]), 64'(want.data));
        if (i_out_data[8] != want.blank)
            report_mismatch("line_blank", 64'(i_out_data[8]), 64'(want.blank));
        if (i_out_data[ROWS_LSB +: REG_BITS] != want.rows)
            report_mismatch("row_count", 64'(i_out_data[ROWS_LSB +: REG_BITS]),
                            64'(want.rows));
        if (i_out_data[DONE_BIT] != want.done)
            report_mismatch("finished", 64'(i_out_data[DONE_BIT]), 64'(want.done));
        if (i_out_last != want.last)
            report_mismatch("last_of_run", 64'(i_out_last), 64'(want.last));
        if (i_out_data[OUT_TDATA_W-1:DONE_BIT+1] != '0)
            report_mismatch("padding", i_out_data, 64'h0);
    endtask

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_start     = '0;
            win_end       = REG_MAX;
            row_limit     = REG_MAX;
            strip_mark    = 1'b0;
            skip_empty    = 1'b0;
            offset        = '0;
            row_total     = '0;
            after_cr      = 1'b0;
            in_line       = 1'b0;
            skipping_head = 1'b0;
            has_ink       = 1'b0;
            halted        = 1'b0;
            marks_held    = 0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPLIT_START: win_start  = i_cfg_data;
                    CFG_SPLIT_END:   win_end    = i_cfg_data;
                    CFG_STRIP_BOM:   strip_mark = i_cfg_data[0];
                    CFG_SKIP_BLANK:  skip_empty = i_cfg_data[0];
                    CFG_MAX_ROWS:    row_limit  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready)
                check_result();
            if (i_in_valid && i_in_ready)
                predict_word(i_in_data, i_in_last);
        end
        o_pending = awaited_results.size();
        o_rows    = row_total;
    end

endmodule

@@ verif/tb_top.sv @@
// testbench top for the text line splitter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top
    import tlsrc_pkg::*;
();

    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 8;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [REG_BITS-1:0]    i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    logic [31:0]            fault_count;
    logic [31:0]            waiting_count;
    logic [REG_BITS-1:0]    rows_seen;

    logic                   quiet;
    logic                   hold_req;
    logic [POS_BITS-1:0]    words_in;
    int unsigned            idle_cycles;

    text_line_splitter_row_counter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    split_result_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .i_out_last  (m_axis_tlast),
        .o_errors    (fault_count),
        .o_pending   (waiting_count),
        .o_rows      (rows_seen)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // idle gap before a byte word: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // line content: mostly printable, some blanks and high bytes, a little noise
    function automatic logic [7:0] pick_content();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'($urandom_range(8'h21, 8'h7e));
        if (r < 68)
            return CH_SPACE;
        if (r < 75)
            return 8'h09;
        if (r < 90)
            return 8'($urandom_range(8'h80, 8'hff));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eof);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = eof;
        do @(posedge i_clk); while (!s_axis_tready);
        words_in = words_in + 1'b1;
    endtask

    // drop valid and wait until every awaited result is out
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (waiting_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one line of random content with lf, cr, cr lf or no terminator
    task automatic send_line();
        int unsigned len;
        int unsigned r;
        r = $urandom_range(0, 99);
        len = (r < 10) ? 0 : (r < 90) ? $urandom_range(1, 8) : $urandom_range(15, 30);
        repeat (len) send_word(pick_content(), 1'b0);
        r = $urandom_range(0, 99);
        if (r < 45) begin
            send_word(CH_LF, 1'b0);
        end else if (r < 70) begin
            send_word(CH_CR, 1'b0);
        end else if (r < 90) begin
            send_word(CH_CR, 1'b0);
            send_word(CH_LF, 1'b0);
        end
    endtask

    task automatic send_text(input int unsigned n);
        logic [POS_BITS-1:0] stop_at;
        stop_at = words_in + n;
        while (words_in < stop_at) send_line();
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin : receiver
        int unsigned stall;
        int unsigned r;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (quiet) begin
                m_axis_tready = 1'b1;
            end else if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                r = $urandom_range(0, 99);
                m_axis_tready = (r < 70);
                if (r >= 96)
                    stall = $urandom_range(9, 29);
                else if (r >= 70)
                    stall = $urandom_range(0, 2);
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        int unsigned mark_case;
        int unsigned end_case;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_SPLIT_START;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        words_in      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // wide open window, mark stripping on
        write_reg(CFG_SPLIT_START, '0);
        write_reg(CFG_SPLIT_END, REG_MAX);
        write_reg(CFG_MAX_ROWS, REG_MAX);
        write_reg(CFG_SKIP_BLANK, '0);
        write_reg(CFG_STRIP_BOM, REG_BITS'(1));

        // full mark, mismatch on third or second byte, or stripping turned off mid-mark
        mark_case = $urandom_range(0, 3);
        send_word(BOM_0, 1'b0);
        case (mark_case)
            0: begin
                send_word(BOM_1, 1'b0);
                send_word(BOM_2, 1'b0);
            end
            1: begin
                send_word(BOM_1, 1'b0);
                send_word(8'h41, 1'b0);
            end
            2: send_word(CH_LF, 1'b0);
            default: begin
                settle();
                write_reg(CFG_STRIP_BOM, '0);
                send_word(BOM_1, 1'b0);
            end
        endcase

        // byte extremes, lf, cr lf, lone cr, empty and blank lines
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(8'h21, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_CR, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(8'h09, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(CH_LF, 1'b0);

        // blank lines no longer counted
        settle();
        write_reg(CFG_SKIP_BLANK, REG_BITS'(1));
        send_word(CH_SPACE, 1'b0);
        send_word(CH_LF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7f, 1'b0);
        send_word(CH_LF, 1'b0);

        // random text in phases with changing settings
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: write_reg(CFG_SKIP_BLANK, REG_BITS'($urandom_range(0, 1)));
                1: begin
                    // far split start drops everything, then a near one skips a partial line
                    write_reg(CFG_SPLIT_START, REG_MAX);
                    repeat (6) send_word(pick_content(), 1'b0);
                    settle();
                    write_reg(CFG_SPLIT_START, words_in + REG_BITS'($urandom_range(2, 12)));
                end
                2: write_reg(CFG_SPLIT_START, '0);
                3: begin
                    write_reg(CFG_SKIP_BLANK, REG_BITS'($urandom_range(0, 1)));
                    quiet = 1'b1;
                end
                default: begin
                    // receiver holds off while bytes keep coming
                    quiet    = 1'b1;
                    hold_req = 1'b1;
                end
            endcase
            send_text(36);
            quiet = 1'b0;
        end

        // closing phase: end of file, row limit, split end, or both at zero
        settle();
        end_case = $urandom_range(0, 3);
        case (end_case)
            0: ;
            1: write_reg(CFG_MAX_ROWS, rows_seen + REG_BITS'($urandom_range(1, 3)));
            2: write_reg(CFG_SPLIT_END, words_in + REG_BITS'($urandom_range(4, 30)));
            default: begin
                write_reg(CFG_MAX_ROWS, '0);
                write_reg(CFG_SPLIT_END, '0);
            end
        endcase
        send_text(30);
        send_word(pick_content(), 1'b1);

        // bytes after scanning stopped
        repeat (5) send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && waiting_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
